### rtl/swaf_pkg.sv
// Shared constants, types and command codes for the sliding-window anagram finder.
package swaf_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int ALPHABET    = 26;
  localparam int LETTER_W    = 5;
  localparam int CMD_W       = 2;
  localparam int INDEX_W     = 32;
  localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
  localparam int PTR_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int DIFF_W      = $clog2(ALPHABET + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2
  } cmd_e;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [DIFF_W-1:0]   diff_t;
  typedef logic [INDEX_W-1:0]  index_t;

  // Decoded operation of the word being processed this cycle.
  typedef struct packed {
    logic    clr;
    logic    pat;
    logic    text;
    logic    dec;
    letter_t letter;
    letter_t old;
  } op_t;

  typedef struct packed {
    logic clr;
    logic pat_inc;
    logic win_inc;
    logic win_dec;
  } lane_ctrl_t;

  typedef struct packed {
    logic to_diff;
    logic to_eq;
  } lane_stat_t;

  typedef struct packed {
    logic    we;
    ptr_t    wa;
    letter_t wd;
    ptr_t    ra;
  } mem_req_t;

endpackage

### rtl/swaf_ifs.sv
// Valid/ready channel interfaces for the input words and the result words.
interface swaf_in_if;
  logic                         valid;
  logic                         ready;
  logic [swaf_pkg::CMD_W-1:0]   cmd;
  logic [swaf_pkg::LETTER_W-1:0] letter;

  modport source (output valid, output cmd, output letter, input ready);
  modport sink   (input valid, input cmd, input letter, output ready);
endinterface

interface swaf_out_if;
  logic                          valid;
  logic                          ready;
  logic [swaf_pkg::INDEX_W-1:0]  start_index;

  modport source (output valid, output start_index, input ready);
  modport sink   (input valid, input start_index, output ready);
endinterface

### rtl/swaf_lane.sv
// One letter lane: pattern and window counts and their match transitions.
module swaf_lane (
  input  logic                   clk,
  input  logic                   rst_n,
  input  swaf_pkg::lane_ctrl_t   ctrl,
  output swaf_pkg::lane_stat_t   stat
);

  swaf_pkg::cnt_t pc_r, pc_nxt;
  swaf_pkg::cnt_t wc_r, wc_nxt;
  logic           eq_now, eq_nxt;

  always_comb begin
    pc_nxt = pc_r;
    wc_nxt = wc_r;
    if (ctrl.clr) begin
      pc_nxt = '0;
      wc_nxt = '0;
    end else begin
      if (ctrl.pat_inc) begin
        pc_nxt = pc_r + 1'b1;
      end
      // A letter that both leaves and enters the window leaves the count alone.
      if (ctrl.win_inc && !ctrl.win_dec) begin
        wc_nxt = wc_r + 1'b1;
      end else if (ctrl.win_dec && !ctrl.win_inc && (wc_r != '0)) begin
        wc_nxt = wc_r - 1'b1;
      end
    end
    eq_now       = (pc_r == wc_r);
    eq_nxt       = (pc_nxt == wc_nxt);
    stat.to_diff = !ctrl.clr && eq_now && !eq_nxt;
    stat.to_eq   = !ctrl.clr && !eq_now && eq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      wc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
      wc_r <= wc_nxt;
    end
  end

endmodule

### rtl/swaf_win_mem.sv
// Circular window store with one write port and one registered, write-through read port.
module swaf_win_mem (
  input  logic                 clk,
  input  swaf_pkg::mem_req_t   req,
  output swaf_pkg::letter_t    rd_data_r
);

  swaf_pkg::letter_t mem [swaf_pkg::MAX_PATTERN];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wa] <= req.wd;
    end
    if (req.we && (req.wa == req.ra)) begin
      rd_data_r <= req.wd;
    end else begin
      rd_data_r <= mem[req.ra];
    end
  end

endmodule

### rtl/swaf_ctrl.sv
// Input register, scalar state, difference count and result register.
module swaf_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  swaf_in_if.sink                              in_ch,
  swaf_out_if.source                           out_ch,
  input  logic [swaf_pkg::ALPHABET-1:0]        to_diff,
  input  logic [swaf_pkg::ALPHABET-1:0]        to_eq,
  input  swaf_pkg::letter_t                    old_letter,
  output swaf_pkg::op_t                        op,
  output swaf_pkg::mem_req_t                   mem_req
);

  localparam int SUM_W = swaf_pkg::CNT_W + 1;

  logic                        in_v_r, in_v_nxt;
  logic [swaf_pkg::CMD_W-1:0]  cmd_r;
  swaf_pkg::letter_t           letter_r;
  swaf_pkg::cnt_t              len_r, len_nxt;
  swaf_pkg::cnt_t              fill_r, fill_nxt;
  swaf_pkg::ptr_t              wr_ptr_r, wr_ptr_nxt;
  swaf_pkg::index_t            pos_r, pos_nxt;
  swaf_pkg::diff_t             diff_r, diff_nxt;
  logic                        out_v_r, out_v_nxt;
  swaf_pkg::index_t            out_idx_r, out_idx_nxt;

  logic                        advance, accept, fire, letter_ok, full, match;
  logic                        do_clear, do_pat, do_text;
  logic [SUM_W-1:0]            rd_sum;

  assign advance      = !out_v_r || out_ch.ready;
  assign in_ch.ready  = !in_v_r || advance;
  assign accept       = in_ch.valid && in_ch.ready;
  assign fire         = in_v_r && advance;

  assign letter_ok = (32'(letter_r) < 32'(swaf_pkg::ALPHABET));
  assign full      = (fill_r >= len_r);
  assign do_clear  = fire && (cmd_r == swaf_pkg::CMD_CLEAR);
  assign do_pat    = fire && (cmd_r == swaf_pkg::CMD_PATTERN) && letter_ok &&
                     (pos_r == '0) && (len_r < swaf_pkg::CNT_W'(swaf_pkg::MAX_PATTERN));
  assign do_text   = fire && (cmd_r == swaf_pkg::CMD_TEXT) && letter_ok && (len_r != '0);

  assign op.clr    = do_clear;
  assign op.pat    = do_pat;
  assign op.text   = do_text;
  assign op.dec    = do_text && full;
  assign op.letter = letter_r;
  assign op.old    = old_letter;

  always_comb begin
    in_v_nxt = accept ? 1'b1 : (fire ? 1'b0 : in_v_r);

    len_nxt    = len_r;
    fill_nxt   = fill_r;
    wr_ptr_nxt = wr_ptr_r;
    pos_nxt    = pos_r;
    if (do_clear) begin
      len_nxt    = '0;
      fill_nxt   = '0;
      wr_ptr_nxt = '0;
      pos_nxt    = '0;
    end else if (do_pat) begin
      len_nxt = len_r + 1'b1;
    end else if (do_text) begin
      if (!full) begin
        fill_nxt = fill_r + 1'b1;
      end
      if ((32'(wr_ptr_r) + 32'd1) >= 32'(swaf_pkg::MAX_PATTERN)) begin
        wr_ptr_nxt = '0;
      end else begin
        wr_ptr_nxt = wr_ptr_r + 1'b1;
      end
      if (pos_r != '1) begin
        pos_nxt = pos_r + 1'b1;
      end
    end

    // At most two lanes change per word, so the count moves by at most two.
    if (do_clear) begin
      diff_nxt = '0;
    end else begin
      diff_nxt = diff_r + swaf_pkg::DIFF_W'($countones(to_diff))
                        - swaf_pkg::DIFF_W'($countones(to_eq));
    end

    match = do_text && (fill_nxt >= len_r) && (diff_nxt == '0);

    out_v_nxt   = out_v_r;
    out_idx_nxt = out_idx_r;
    if (advance) begin
      out_v_nxt   = match;
      out_idx_nxt = pos_nxt - swaf_pkg::INDEX_W'(len_r);
    end

    // Prefetch the letter that will leave the window on the next text word.
    rd_sum = SUM_W'(wr_ptr_nxt) + SUM_W'(swaf_pkg::MAX_PATTERN) - SUM_W'(len_nxt);
    if (rd_sum >= SUM_W'(swaf_pkg::MAX_PATTERN)) begin
      mem_req.ra = swaf_pkg::PTR_W'(rd_sum - SUM_W'(swaf_pkg::MAX_PATTERN));
    end else begin
      mem_req.ra = swaf_pkg::PTR_W'(rd_sum);
    end
    mem_req.we = do_text;
    mem_req.wa = wr_ptr_r;
    mem_req.wd = letter_r;
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.start_index = out_idx_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_ch.cmd;
      letter_r <= in_ch.letter;
    end
    out_idx_r <= out_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      len_r    <= '0;
      fill_r   <= '0;
      wr_ptr_r <= '0;
      pos_r    <= '0;
      diff_r   <= '0;
      out_v_r  <= 1'b0;
    end else begin
      in_v_r   <= in_v_nxt;
      len_r    <= len_nxt;
      fill_r   <= fill_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      pos_r    <= pos_nxt;
      diff_r   <= diff_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

endmodule

### rtl/sliding_window_anagram_finder_unit.sv
// Top level of the sliding-window anagram finder: lanes, window store and control.
//
//   Channel  Direction  Payload                         Handshake
//   in_ch    sink       cmd[1:0], letter[4:0]           valid/ready
//   out_ch   source     start_index[31:0]               valid/ready
//
// A word is registered on acceptance and processed once the output register can
// advance, when its result, if any, is written to the output register; out_ch.valid
// therefore rises when that result is registered, and one word can be taken in
// every cycle while out_ch.ready does not hold the output.
// The letter leaving the window is read ahead from the window store,
// using the pointer and length that the current word leaves behind.
// Reset (rst_n low, synchronous) empties both histograms and zeroes the length,
// position, fill, pointer and difference count; the window store is not cleared.
// When a result waits in the output register and out_ch.ready is low, the
// processing stage holds, and in_ch.ready falls once the input register is full.
module sliding_window_anagram_finder_unit (
  input  logic        clk,
  input  logic        rst_n,
  swaf_in_if.sink     in_ch,
  swaf_out_if.source  out_ch
);

  swaf_pkg::op_t         op;
  swaf_pkg::mem_req_t    mem_req;
  swaf_pkg::letter_t     old_letter;
  swaf_pkg::lane_ctrl_t  lane_ctrl [swaf_pkg::ALPHABET];
  swaf_pkg::lane_stat_t  lane_stat [swaf_pkg::ALPHABET];
  logic [swaf_pkg::ALPHABET-1:0] to_diff;
  logic [swaf_pkg::ALPHABET-1:0] to_eq;

  // Sequencing, scalar state and the result register.
  swaf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .to_diff    (to_diff),
    .to_eq      (to_eq),
    .old_letter (old_letter),
    .op         (op),
    .mem_req    (mem_req)
  );

  // Letters of the current window, in arrival order around a circular pointer.
  swaf_win_mem u_win_mem (
    .clk       (clk),
    .req       (mem_req),
    .rd_data_r (old_letter)
  );

  // One lane per letter of the alphabet. Each lane owns its pattern and
  // window counts and reports whether this word makes them start or stop
  // differing, which the control folds into the running difference count.
  for (genvar i = 0; i < swaf_pkg::ALPHABET; i++) begin : g_lane
    assign lane_ctrl[i].clr     = op.clr;
    assign lane_ctrl[i].pat_inc = op.pat  && (32'(op.letter) == 32'(i));
    assign lane_ctrl[i].win_inc = op.text && (32'(op.letter) == 32'(i));
    assign lane_ctrl[i].win_dec = op.dec  && (32'(op.old) == 32'(i));

    swaf_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (lane_ctrl[i]),
      .stat  (lane_stat[i])
    );

    assign to_diff[i] = lane_stat[i].to_diff;
    assign to_eq[i]   = lane_stat[i].to_eq;
  end

endmodule
